### rtl/dequ_pkg.sv
// Shared types and constants for the double-ended queue unit.
package dequ_pkg;

	localparam int DATA_W = 32;
	localparam int CMD_W = 3;
	localparam int STATUS_W = 2;

	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_QUERY      = 3'd4
	} command_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} state_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] front;
		logic signed [DATA_W-1:0] back;
	} result_t;

endpackage

### rtl/dequ_mem.sv
// Entry storage: one write port, one read port, registered read data.
module dequ_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [dequ_pkg::DATA_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [dequ_pkg::DATA_W-1:0] rd_data
);
	import dequ_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/dequ_ctrl.sv
// Index, count and end-value tracking; issues entry writes and refill reads.
module dequ_ctrl #(
	parameter int DEPTH = 64,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  logic [dequ_pkg::CMD_W-1:0]         command,
	input  logic signed [dequ_pkg::DATA_W-1:0] value,
	input  logic                               out_free,
	output logic                               res_load,
	output dequ_pkg::result_t                  res,
	output logic [CW-1:0]                      res_count,
	output logic                               wr_en,
	output logic [AW-1:0]                      wr_addr,
	output logic [dequ_pkg::DATA_W-1:0]        wr_data,
	output logic                               rd_en,
	output logic [AW-1:0]                      rd_addr,
	input  logic [dequ_pkg::DATA_W-1:0]        rd_data
);
	import dequ_pkg::*;

	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	state_t state_q, state_d;

	logic [AW-1:0] front_idx_q, front_idx_d;
	logic [AW-1:0] back_idx_q, back_idx_d;
	logic [CW-1:0] count_q, count_d;
	logic signed [DATA_W-1:0] front_val_q, front_val_d;
	logic signed [DATA_W-1:0] back_val_q, back_val_d;
	status_t status_q, status_d;
	logic refill_front_q, refill_front_d;
	logic need_read;
	logic accept;
	logic full;
	logic empty;
	logic [AW-1:0] front_next;
	logic [AW-1:0] front_prev;
	logic [AW-1:0] back_prev;
	logic [AW-1:0] back_prev2;

	assign full = (count_q == FULL_COUNT);
	assign empty = (count_q == '0);
	assign front_next = (front_idx_q == LAST_SLOT) ? '0 : front_idx_q + AW'(1);
	assign front_prev = (front_idx_q == '0) ? LAST_SLOT : front_idx_q - AW'(1);
	assign back_prev = (back_idx_q == '0) ? LAST_SLOT : back_idx_q - AW'(1);
	assign back_prev2 = (back_prev == '0) ? LAST_SLOT : back_prev - AW'(1);
	assign accept = cmd_valid && cmd_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && need_read) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd_ready = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = out_free;
				res_load = accept && !need_read;
			end
			ST_READ: begin
				res_load = 1'b1;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	// command decode
	always_comb begin
		front_idx_d = front_idx_q;
		back_idx_d = back_idx_q;
		count_d = count_q;
		front_val_d = front_val_q;
		back_val_d = back_val_q;
		status_d = STATUS_OK;
		refill_front_d = refill_front_q;
		need_read = 1'b0;
		wr_en = 1'b0;
		wr_addr = back_idx_q;
		wr_data = value;
		rd_addr = front_next;
		unique case (command)
			CMD_PUSH_BACK: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					wr_en = accept;
					wr_addr = back_idx_q;
					back_idx_d = (back_idx_q == LAST_SLOT) ? '0 : back_idx_q + AW'(1);
					count_d = count_q + CW'(1);
					back_val_d = value;
					if (empty) begin
						front_val_d = value;
					end
				end
			end
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					wr_en = accept;
					wr_addr = front_prev;
					front_idx_d = front_prev;
					count_d = count_q + CW'(1);
					front_val_d = value;
					if (empty) begin
						back_val_d = value;
					end
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					front_idx_d = front_next;
					count_d = count_q - CW'(1);
					if (count_q == CW'(1)) begin
						front_val_d = EMPTY_VALUE;
						back_val_d = EMPTY_VALUE;
					end else begin
						need_read = 1'b1;
						rd_addr = front_next;
						refill_front_d = 1'b1;
					end
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					back_idx_d = back_prev;
					count_d = count_q - CW'(1);
					if (count_q == CW'(1)) begin
						front_val_d = EMPTY_VALUE;
						back_val_d = EMPTY_VALUE;
					end else begin
						need_read = 1'b1;
						rd_addr = back_prev2;
						refill_front_d = 1'b0;
					end
				end
			end
			default: begin
				status_d = STATUS_OK;
			end
		endcase
	end

	assign rd_en = accept && need_read;

	// result to output register
	always_comb begin
		if (state_q == ST_READ) begin
			res.status = status_q;
			res.front = refill_front_q ? $signed(rd_data) : front_val_q;
			res.back = refill_front_q ? back_val_q : $signed(rd_data);
			res_count = count_q;
		end else begin
			res.status = status_d;
			res.front = front_val_d;
			res.back = back_val_d;
			res_count = count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_idx_q <= '0;
			back_idx_q <= '0;
			count_q <= '0;
			front_val_q <= EMPTY_VALUE;
			back_val_q <= EMPTY_VALUE;
			status_q <= STATUS_OK;
			refill_front_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				front_idx_q <= front_idx_d;
				back_idx_q <= back_idx_d;
				count_q <= count_d;
				front_val_q <= front_val_d;
				back_val_q <= back_val_d;
				status_q <= status_d;
				refill_front_q <= refill_front_d;
			end else if (state_q == ST_READ) begin
				if (refill_front_q) begin
					front_val_q <= $signed(rd_data);
				end else begin
					back_val_q <= $signed(rd_data);
				end
			end
		end
	end

endmodule

### rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: control, entry storage, response register.
//
//   channel  | handshake              | payload
//   command  | cmd_valid / cmd_ready  | command, value
//   response | rsp_valid / rsp_ready  | status, front_value, back_value, entry_count
//
// Pushes, queries, rejected commands and pops that empty the queue load the response
// register on accept; other pops first fetch the new end value from the storage read port.
// Reset clears indices and count; storage holds garbage until written.
// A response waiting in the output register does not block the next command transfer,
// as long as it is taken in the same cycle.
module double_ended_queue_unit #(
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cmd_valid,
	output logic                                   cmd_ready,
	input  logic [dequ_pkg::CMD_W-1:0]             command,
	input  logic signed [dequ_pkg::DATA_W-1:0]     value,
	output logic                                   rsp_valid,
	input  logic                                   rsp_ready,
	output logic [dequ_pkg::STATUS_W-1:0]          status,
	output logic signed [dequ_pkg::DATA_W-1:0]     front_value,
	output logic signed [dequ_pkg::DATA_W-1:0]     back_value,
	output logic [$clog2(DEPTH+1)-1:0]             entry_count
);
	import dequ_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic out_free;
	logic res_load;
	result_t res;
	logic [CW-1:0] res_count;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic [DATA_W-1:0] rd_data;

	logic rsp_valid_q;
	result_t rsp_q;
	logic [CW-1:0] rsp_count_q;

	assign out_free = !rsp_valid_q || rsp_ready;

	dequ_ctrl #(
		.DEPTH(DEPTH),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.command(command),
		.value(value),
		.out_free(out_free),
		.res_load(res_load),
		.res(res),
		.res_count(res_count),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	dequ_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res;
			rsp_count_q <= res_count;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = rsp_q.status;
	assign front_value = rsp_q.front;
	assign back_value = rsp_q.back;
	assign entry_count = rsp_count_q;

endmodule
